// ----- hdl/trade_bar_ohlc_aggregator_top_macros.svh -----
// assertion macros shared by the aggregator rtl
`ifndef TRADE_BAR_OHLC_AGGREGATOR_TOP_MACROS_SVH
`define TRADE_BAR_OHLC_AGGREGATOR_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TBOA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tboa same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define TBOA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tboa next-cycle check failed");

`endif

// ----- hdl/tboa_pkg.sv -----
package tboa_pkg;

   // field widths
   localparam int VOL_W       = 32;
   localparam int AMT_W       = 48;
   localparam int VOL_TOT_W   = 40;
   localparam int AMT_TOT_W   = 56;
   localparam int PRICE_W     = 32;
   localparam int COUNT_OUT_W = 10;
   localparam int CFG_W       = 10;

   // combined volume and amount of one request
   localparam int VOL_SUM_W = VOL_W + 1;
   localparam int AMT_SUM_W = AMT_W + 1;

   // digit width of the serial accumulators
   localparam int DIGIT_W = 2;

   // minimum interval count after reset: three hours of minute bars
   localparam logic [CFG_W-1:0] MIN_INTERVALS_RESET = CFG_W'(60 * 3);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic clear;
   } acc_ctl_type;

endpackage

// ----- hdl/tboa_acc.sv -----
module tboa_acc #(
   parameter int TOT_W = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tboa_pkg::acc_ctl_type ctl,
   input  logic [TOT_W-1:0]      addend,
   output logic [TOT_W-1:0]      total,
   output logic                  busy
);

   localparam int DW   = tboa_pkg::DIGIT_W;
   localparam int NDIG = TOT_W / DW;
   localparam int CW   = $clog2(NDIG);

   logic [TOT_W-1:0] acc_ff, acc_in;
   logic [TOT_W-1:0] add_ff, add_in;
   logic             carry_ff, carry_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DW:0]      digit_sum;
   logic             last_digit;

   // one digit of the running total per cycle, rotating through the register
   always_comb begin
      digit_sum  = {1'b0, acc_ff[DW-1:0]} + {1'b0, add_ff[DW-1:0]} + {{DW{1'b0}}, carry_ff};
      last_digit = (cnt_ff == CW'(NDIG - 1));
      acc_in     = acc_ff;
      add_in     = add_ff;
      carry_in   = carry_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end
      if (ctl.start) begin
         add_in   = addend;
         carry_in = 1'b0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in   = {digit_sum[DW-1:0], acc_ff[TOT_W-1:DW]};
         add_in   = add_ff >> DW;
         carry_in = digit_sum[DW];
         cnt_in   = cnt_ff + CW'(1);
         if (last_digit) begin
            busy_in = 1'b0;
            // carry out of the top digit: clamp to all ones
            if (digit_sum[DW]) begin
               acc_in = '1;
            end
         end
      end
   end

   // control and running total
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         carry_ff <= 1'b0;
         cnt_ff   <= '0;
         busy_ff  <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         carry_ff <= carry_in;
         cnt_ff   <= cnt_in;
         busy_ff  <= busy_in;
      end
   end

   // addend shift register
   always_ff @(posedge clock) begin
      add_ff <= add_in;
   end

   assign total = acc_ff;
   assign busy  = busy_ff;

endmodule

// ----- hdl/tboa_div.sv -----
module tboa_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tboa_pkg::AMT_SUM_W-1:0] dividend,
   input  logic [tboa_pkg::VOL_SUM_W-1:0] divisor,
   output logic [tboa_pkg::PRICE_W-1:0]   quotient,
   output logic                           busy,
   output logic                           last_step
);

   localparam int QW   = tboa_pkg::PRICE_W;
   localparam int DVW  = tboa_pkg::VOL_SUM_W;
   localparam int DDW  = tboa_pkg::AMT_SUM_W;
   localparam int HI_W = DDW - QW;
   localparam int CW   = $clog2(QW);

   logic [DVW-1:0] rem_ff, rem_in;
   logic [QW-1:0]  q_ff, q_in;
   logic [DVW-1:0] div_ff, div_in;
   logic           sat_ff, sat_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic [DVW:0]   trial;
   logic [DVW:0]   diff;
   logic           fits;
   logic [DVW-1:0] hi_part;

   // restoring radix-2 step; low dividend bits leave the top of q_ff as quotient bits enter
   always_comb begin
      trial   = {rem_ff, q_ff[QW-1]};
      fits    = (trial >= {1'b0, div_ff});
      diff    = trial - {1'b0, div_ff};
      hi_part = {{(DVW - HI_W){1'b0}}, dividend[DDW-1:QW]};
      rem_in  = rem_ff;
      q_in    = q_ff;
      div_in  = div_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         // upper part at or above the divisor means the quotient needs more than 32 bits
         rem_in  = hi_part;
         q_in    = dividend[QW-1:0];
         div_in  = divisor;
         sat_in  = (hi_part >= divisor);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVW-1:0] : trial[DVW-1:0];
         q_in   = {q_ff[QW-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      div_ff <= div_in;
      sat_ff <= sat_in;
   end

   assign last_step = busy_ff && (cnt_ff == CW'(QW - 1));
   assign busy      = busy_ff;
   assign quotient  = sat_ff ? '1 : q_ff;

endmodule

// ----- hdl/trade_bar_ohlc_aggregator_top.sv -----
// channel   direction  handshake                 payload
// req       in         req_valid / req_ready     interval volumes, amounts, last_in_row
// rsp       out        rsp_valid / rsp_ready     row totals, ohlc prices, count, flags
// csr       in         csr_wr_en                 min_intervals
//
// a request is accepted, then runs through the 32 steps of the bit-serial price divider
// and then updates the price registers; the divider loop sets how long a request takes.
// the saturating totals run two bits a cycle alongside the divider and finish first.
// a row result sits in the output register while the next request is taken; a row end
// waits in the update cycle only while an earlier result is still not taken.
// synchronous reset clears the row state, loads min_intervals with 180 and drops rsp_valid.
`include "trade_bar_ohlc_aggregator_top_macros.svh"

module trade_bar_ohlc_aggregator_top #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tboa_pkg::VOL_W-1:0]       req_sell_volume,
   input  logic [tboa_pkg::AMT_W-1:0]       req_sell_amount,
   input  logic [tboa_pkg::VOL_W-1:0]       req_buy_volume,
   input  logic [tboa_pkg::AMT_W-1:0]       req_buy_amount,
   input  logic                             req_last_in_row,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tboa_pkg::VOL_TOT_W-1:0]   rsp_sell_volume_total,
   output logic [tboa_pkg::AMT_TOT_W-1:0]   rsp_sell_amount_total,
   output logic [tboa_pkg::VOL_TOT_W-1:0]   rsp_buy_volume_total,
   output logic [tboa_pkg::AMT_TOT_W-1:0]   rsp_buy_amount_total,
   output logic [tboa_pkg::PRICE_W-1:0]     rsp_open_price,
   output logic [tboa_pkg::PRICE_W-1:0]     rsp_close_price,
   output logic [tboa_pkg::PRICE_W-1:0]     rsp_high_price,
   output logic [tboa_pkg::PRICE_W-1:0]     rsp_low_price,
   output logic [tboa_pkg::COUNT_OUT_W-1:0] rsp_interval_count,
   output logic                             rsp_kept,
   output logic                             rsp_zero_volume_seen,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [tboa_pkg::CFG_W-1:0]       csr_wr_data
);

   localparam int PW   = tboa_pkg::PRICE_W;
   localparam int VTW  = tboa_pkg::VOL_TOT_W;
   localparam int ATW  = tboa_pkg::AMT_TOT_W;
   localparam int COW  = tboa_pkg::COUNT_OUT_W;
   localparam int CFW  = tboa_pkg::CFG_W;
   localparam int EXTW = ((COUNT_WIDTH > COW) ? COUNT_WIDTH : COW) + 1;
   localparam int CMPW = ((COUNT_WIDTH > CFW) ? COUNT_WIDTH : CFW) + 1;

   tboa_pkg::state_type state_ff, state_in;
   tboa_pkg::acc_ctl_type acc_ctl;

   logic [CFW-1:0]         min_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic                   first_ff, first_in;
   logic                   error_ff;
   logic [PW-1:0]          open_ff, open_in;
   logic [PW-1:0]          close_ff, close_in;
   logic [PW-1:0]          high_ff, high_in;
   logic [PW-1:0]          low_ff, low_in;
   logic                   last_ff;
   logic                   vol_nz_ff;

   logic [tboa_pkg::VOL_SUM_W-1:0] vol_sum;
   logic [tboa_pkg::AMT_SUM_W-1:0] amt_sum;
   logic [PW-1:0]  price;
   logic           div_start, div_busy, div_last_step;
   logic           accept, commit, emit;
   logic [VTW-1:0] sv_total, bv_total;
   logic [ATW-1:0] sa_total, ba_total;
   logic           sv_busy, sa_busy, bv_busy, ba_busy, acc_busy_any;
   logic [EXTW-1:0] count_ext;
   logic [COW-1:0]  count_out;
   logic            kept;

   logic              rsp_valid_ff;
   logic [VTW-1:0]    rsp_sv_ff, rsp_bv_ff;
   logic [ATW-1:0]    rsp_sa_ff, rsp_ba_ff;
   logic [PW-1:0]     rsp_open_ff, rsp_close_ff, rsp_high_ff, rsp_low_ff;
   logic [COW-1:0]    rsp_count_ff;
   logic              rsp_kept_ff, rsp_zero_ff;

   // combined volume and amount of the incoming request
   assign vol_sum = {1'b0, req_sell_volume} + {1'b0, req_buy_volume};
   assign amt_sum = {1'b0, req_sell_amount} + {1'b0, req_buy_amount};

   // serial saturating row totals
   tboa_acc #(.TOT_W(VTW)) u_sv_acc (
      .clock(clock), .reset(reset), .ctl(acc_ctl),
      .addend(VTW'(req_sell_volume)), .total(sv_total), .busy(sv_busy)
   );
   tboa_acc #(.TOT_W(ATW)) u_sa_acc (
      .clock(clock), .reset(reset), .ctl(acc_ctl),
      .addend(ATW'(req_sell_amount)), .total(sa_total), .busy(sa_busy)
   );
   tboa_acc #(.TOT_W(VTW)) u_bv_acc (
      .clock(clock), .reset(reset), .ctl(acc_ctl),
      .addend(VTW'(req_buy_volume)), .total(bv_total), .busy(bv_busy)
   );
   tboa_acc #(.TOT_W(ATW)) u_ba_acc (
      .clock(clock), .reset(reset), .ctl(acc_ctl),
      .addend(ATW'(req_buy_amount)), .total(ba_total), .busy(ba_busy)
   );
   assign acc_busy_any = sv_busy | sa_busy | bv_busy | ba_busy;

   // bit-serial average price
   tboa_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(amt_sum), .divisor(vol_sum), .quotient(price),
      .busy(div_busy), .last_step(div_last_step)
   );

   // interval count as emitted, and the keep decision
   always_comb begin
      count_ext = EXTW'(count_ff);
      count_out = (count_ext > EXTW'(2**COW - 1)) ? '1 : count_ext[COW-1:0];
      kept      = (CMPW'(count_ff) > CMPW'(min_ff));
   end

   // sequencer and price update
   always_comb begin
      state_in  = state_ff;
      req_ready = (state_ff == tboa_pkg::ST_IDLE);
      acc_ctl   = '0;
      div_start = 1'b0;
      commit    = 1'b0;
      emit      = 1'b0;
      first_in  = first_ff;
      open_in   = open_ff;
      close_in  = close_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      if (vol_nz_ff) begin
         if (first_ff) begin
            open_in  = price;
            close_in = price;
            high_in  = price;
            low_in   = price;
            first_in = 1'b0;
         end else begin
            close_in = price;
            if (price > high_ff) begin
               high_in = price;
            end else if (price < low_ff) begin
               low_in = price;
            end
         end
      end
      case (state_ff)
         tboa_pkg::ST_IDLE: begin
            if (req_valid) begin
               acc_ctl.start = 1'b1;
               div_start     = 1'b1;
               state_in      = tboa_pkg::ST_RUN;
            end
         end
         tboa_pkg::ST_RUN: begin
            if (div_last_step && !acc_busy_any) begin
               state_in = tboa_pkg::ST_DONE;
            end
         end
         tboa_pkg::ST_DONE: begin
            if (!last_ff) begin
               commit   = 1'b1;
               state_in = tboa_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               commit        = 1'b1;
               emit          = 1'b1;
               acc_ctl.clear = 1'b1;
               state_in      = tboa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tboa_pkg::ST_IDLE;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   // control and row state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tboa_pkg::ST_IDLE;
         min_ff       <= tboa_pkg::MIN_INTERVALS_RESET;
         count_ff     <= '0;
         first_ff     <= 1'b1;
         error_ff     <= 1'b0;
         open_ff      <= '0;
         close_ff     <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            min_ff <= csr_wr_data;
         end
         if (accept) begin
            if (count_ff != '1) begin
               count_ff <= count_ff + COUNT_WIDTH'(1);
            end
            if (vol_sum == '0) begin
               error_ff <= 1'b1;
            end
         end
         // row end: start a fresh row, otherwise take the price update
         if (emit) begin
            count_ff <= '0;
            first_ff <= 1'b1;
            error_ff <= 1'b0;
            open_ff  <= '0;
            close_ff <= '0;
            high_ff  <= '0;
            low_ff   <= '0;
         end else if (commit) begin
            first_ff <= first_in;
            open_ff  <= open_in;
            close_ff <= close_in;
            high_ff  <= high_in;
            low_ff   <= low_in;
         end
         // result valid
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request flags held for the update cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff   <= req_last_in_row;
         vol_nz_ff <= (vol_sum != '0);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_sv_ff    <= sv_total;
         rsp_sa_ff    <= sa_total;
         rsp_bv_ff    <= bv_total;
         rsp_ba_ff    <= ba_total;
         rsp_open_ff  <= open_in;
         rsp_close_ff <= close_in;
         rsp_high_ff  <= high_in;
         rsp_low_ff   <= low_in;
         rsp_count_ff <= count_out;
         rsp_kept_ff  <= kept;
         rsp_zero_ff  <= error_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_sell_volume_total = rsp_sv_ff;
   assign rsp_sell_amount_total = rsp_sa_ff;
   assign rsp_buy_volume_total  = rsp_bv_ff;
   assign rsp_buy_amount_total  = rsp_ba_ff;
   assign rsp_open_price        = rsp_open_ff;
   assign rsp_close_price       = rsp_close_ff;
   assign rsp_high_price        = rsp_high_ff;
   assign rsp_low_price         = rsp_low_ff;
   assign rsp_interval_count    = rsp_count_ff;
   assign rsp_kept              = rsp_kept_ff;
   assign rsp_zero_volume_seen  = rsp_zero_ff;

   // checks
   `TBOA_ASSERT_NEXT(a_accept_starts_div, clock, reset, (state_ff == tboa_pkg::ST_IDLE && req_valid), div_busy)
   `TBOA_ASSERT_NOW(a_update_units_idle, clock, reset, (state_ff == tboa_pkg::ST_DONE), (!div_busy && !acc_busy_any))
   `TBOA_ASSERT_NEXT(a_row_end_waits, clock, reset, (state_ff == tboa_pkg::ST_DONE && last_ff && rsp_valid_ff && !rsp_ready), (state_ff == tboa_pkg::ST_DONE))
   `TBOA_ASSERT_NEXT(a_emit_clears_row, clock, reset, emit, (count_ff == '0 && first_ff && !error_ff && rsp_valid_ff))

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int DRAIN_CYCLES    = 80;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int COUNT_SAT       = 1023;
   localparam int MAX_REPORTS     = 10;

   localparam int VOL_W       = tboa_pkg::VOL_W;
   localparam int AMT_W       = tboa_pkg::AMT_W;
   localparam int VOL_TOT_W   = tboa_pkg::VOL_TOT_W;
   localparam int AMT_TOT_W   = tboa_pkg::AMT_TOT_W;
   localparam int PRICE_W     = tboa_pkg::PRICE_W;
   localparam int COUNT_OUT_W = tboa_pkg::COUNT_OUT_W;
   localparam int CFG_W       = tboa_pkg::CFG_W;

   localparam bit [63:0] VOL_TOT_MAX = (64'd1 << VOL_TOT_W) - 64'd1;
   localparam bit [63:0] AMT_TOT_MAX = (64'd1 << AMT_TOT_W) - 64'd1;
   localparam bit [63:0] PRICE_MAX   = (64'd1 << PRICE_W) - 64'd1;

   typedef struct {
      logic [VOL_W-1:0] sell_volume;
      logic [AMT_W-1:0] sell_amount;
      logic [VOL_W-1:0] buy_volume;
      logic [AMT_W-1:0] buy_amount;
      logic             last_in_row;
   } interval_type;

   typedef struct {
      logic [VOL_TOT_W-1:0]   sell_volume_total;
      logic [AMT_TOT_W-1:0]   sell_amount_total;
      logic [VOL_TOT_W-1:0]   buy_volume_total;
      logic [AMT_TOT_W-1:0]   buy_amount_total;
      logic [PRICE_W-1:0]     open_price;
      logic [PRICE_W-1:0]     close_price;
      logic [PRICE_W-1:0]     high_price;
      logic [PRICE_W-1:0]     low_price;
      logic [COUNT_OUT_W-1:0] interval_count;
      logic                   kept;
      logic                   zero_volume_seen;
   } bar_type;

   // running row state and the queue of bars still to come out
   class ohlc_bar_tracker_type;
      bar_type          pending_bars[$];
      int               failures;
      logic [CFG_W-1:0] min_intervals;
      bit [63:0]        sell_vol_sum, sell_amt_sum, buy_vol_sum, buy_amt_sum;
      bit [PRICE_W-1:0] open_px, close_px, high_px, low_px;
      int unsigned      row_count;
      bit               awaiting_open;
      bit               zero_vol_seen;

      function new();
         failures      = 0;
         min_intervals = tboa_pkg::MIN_INTERVALS_RESET;
         clear_row();
      endfunction

      function void clear_row();
         sell_vol_sum  = '0;
         sell_amt_sum  = '0;
         buy_vol_sum   = '0;
         buy_amt_sum   = '0;
         open_px       = '0;
         close_px      = '0;
         high_px       = '0;
         low_px        = '0;
         row_count     = 0;
         awaiting_open = 1'b1;
         zero_vol_seen = 1'b0;
      endfunction

      function bit [63:0] sat_add(bit [63:0] acc, bit [63:0] inc, bit [63:0] limit);
         bit [63:0] s;
         s = acc + inc;
         return (s > limit) ? limit : s;
      endfunction

      // fold one accepted request into the row, closing the bar on the row end
      function void add_interval(interval_type iv);
         bit [63:0] vol, amt, quot;
         bar_type   bar;
         sell_vol_sum = sat_add(sell_vol_sum, 64'(iv.sell_volume), VOL_TOT_MAX);
         sell_amt_sum = sat_add(sell_amt_sum, 64'(iv.sell_amount), AMT_TOT_MAX);
         buy_vol_sum  = sat_add(buy_vol_sum, 64'(iv.buy_volume), VOL_TOT_MAX);
         buy_amt_sum  = sat_add(buy_amt_sum, 64'(iv.buy_amount), AMT_TOT_MAX);
         if (row_count < COUNT_SAT) row_count++;

         vol = 64'(iv.sell_volume) + 64'(iv.buy_volume);
         amt = 64'(iv.sell_amount) + 64'(iv.buy_amount);
         if (vol == 0) begin
            zero_vol_seen = 1'b1;
         end else begin
            quot = amt / vol;
            if (quot > PRICE_MAX) quot = PRICE_MAX;
            if (awaiting_open) begin
               open_px       = quot[PRICE_W-1:0];
               close_px      = quot[PRICE_W-1:0];
               high_px       = quot[PRICE_W-1:0];
               low_px        = quot[PRICE_W-1:0];
               awaiting_open = 1'b0;
            end else begin
               close_px = quot[PRICE_W-1:0];
               if (quot[PRICE_W-1:0] > high_px) high_px = quot[PRICE_W-1:0];
               else if (quot[PRICE_W-1:0] < low_px) low_px = quot[PRICE_W-1:0];
            end
         end

         if (iv.last_in_row) begin
            bar.sell_volume_total = sell_vol_sum[VOL_TOT_W-1:0];
            bar.sell_amount_total = sell_amt_sum[AMT_TOT_W-1:0];
            bar.buy_volume_total  = buy_vol_sum[VOL_TOT_W-1:0];
            bar.buy_amount_total  = buy_amt_sum[AMT_TOT_W-1:0];
            bar.open_price        = open_px;
            bar.close_price       = close_px;
            bar.high_price        = high_px;
            bar.low_price         = low_px;
            bar.interval_count    = COUNT_OUT_W'(row_count);
            bar.kept              = (row_count > min_intervals);
            bar.zero_volume_seen  = zero_vol_seen;
            pending_bars          = {pending_bars, bar};
            clear_row();
         end
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
      endfunction

      function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (act_v !== exp_v)
            note_failure($sformatf("%s expected %0h actual %0h", name, exp_v, act_v));
      endfunction

      // compare a bar leaving the block with the oldest one predicted
      function void check_bar(bar_type got);
         bar_type want;
         if (pending_bars.size() == 0) begin
            note_failure("bar arrived with none predicted");
            return;
         end
         want = pending_bars.pop_front();
         check_field("sell_volume_total", 64'(want.sell_volume_total),
                     64'(got.sell_volume_total));
         check_field("sell_amount_total", 64'(want.sell_amount_total),
                     64'(got.sell_amount_total));
         check_field("buy_volume_total", 64'(want.buy_volume_total),
                     64'(got.buy_volume_total));
         check_field("buy_amount_total", 64'(want.buy_amount_total),
                     64'(got.buy_amount_total));
         check_field("open_price", 64'(want.open_price), 64'(got.open_price));
         check_field("close_price", 64'(want.close_price), 64'(got.close_price));
         check_field("high_price", 64'(want.high_price), 64'(got.high_price));
         check_field("low_price", 64'(want.low_price), 64'(got.low_price));
         check_field("interval_count", 64'(want.interval_count), 64'(got.interval_count));
         check_field("kept", 64'(want.kept), 64'(got.kept));
         check_field("zero_volume_seen", 64'(want.zero_volume_seen),
                     64'(got.zero_volume_seen));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [VOL_W-1:0]       req_sell_volume = '0;
   logic [AMT_W-1:0]       req_sell_amount = '0;
   logic [VOL_W-1:0]       req_buy_volume = '0;
   logic [AMT_W-1:0]       req_buy_amount = '0;
   logic                   req_last_in_row = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [VOL_TOT_W-1:0]   rsp_sell_volume_total;
   logic [AMT_TOT_W-1:0]   rsp_sell_amount_total;
   logic [VOL_TOT_W-1:0]   rsp_buy_volume_total;
   logic [AMT_TOT_W-1:0]   rsp_buy_amount_total;
   logic [PRICE_W-1:0]     rsp_open_price;
   logic [PRICE_W-1:0]     rsp_close_price;
   logic [PRICE_W-1:0]     rsp_high_price;
   logic [PRICE_W-1:0]     rsp_low_price;
   logic [COUNT_OUT_W-1:0] rsp_interval_count;
   logic                   rsp_kept;
   logic                   rsp_zero_volume_seen;
   logic                   csr_wr_en = 1'b0;
   logic [CFG_W-1:0]       csr_wr_data = '0;

   ohlc_bar_tracker_type bar_board = new();
   bit                   no_idle = 1'b0;
   bit                   hold_off_req = 1'b0;

   trade_bar_ohlc_aggregator_top i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_sell_volume       (req_sell_volume),
      .req_sell_amount       (req_sell_amount),
      .req_buy_volume        (req_buy_volume),
      .req_buy_amount        (req_buy_amount),
      .req_last_in_row       (req_last_in_row),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_sell_volume_total (rsp_sell_volume_total),
      .rsp_sell_amount_total (rsp_sell_amount_total),
      .rsp_buy_volume_total  (rsp_buy_volume_total),
      .rsp_buy_amount_total  (rsp_buy_amount_total),
      .rsp_open_price        (rsp_open_price),
      .rsp_close_price       (rsp_close_price),
      .rsp_high_price        (rsp_high_price),
      .rsp_low_price         (rsp_low_price),
      .rsp_interval_count    (rsp_interval_count),
      .rsp_kept              (rsp_kept),
      .rsp_zero_volume_seen  (rsp_zero_volume_seen),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // volumes: zero, full scale, tiny or anything; heavy rows lean on full scale
   function automatic logic [VOL_W-1:0] rand_volume(bit heavy);
      int pick;
      pick = $urandom_range(0, 9);
      if (heavy && $urandom_range(0, 1) == 0) return '1;
      case (pick)
         0: return '0;
         1: return '1;
         2, 3: return VOL_W'($urandom_range(1, 15));
         default: return VOL_W'($urandom);
      endcase
   endfunction

   function automatic logic [AMT_W-1:0] rand_amount(bit heavy);
      int pick;
      pick = $urandom_range(0, 9);
      if (heavy && $urandom_range(0, 1) == 0) return '1;
      case (pick)
         0: return '0;
         1: return '1;
         2, 3: return AMT_W'($urandom_range(0, 4095));
         default: return AMT_W'({$urandom, $urandom});
      endcase
   endfunction

   // offer one request and hold it until the block takes it
   task automatic send_request(input logic [VOL_W-1:0] sv, input logic [AMT_W-1:0] sa,
                               input logic [VOL_W-1:0] bv, input logic [AMT_W-1:0] ba,
                               input logic last);
      interval_type iv;
      int           gap;
      gap = 0;
      while (!no_idle && $urandom_range(0, 99) < 14) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sell_volume <= sv;
      req_sell_amount <= sa;
      req_buy_volume  <= bv;
      req_buy_amount  <= ba;
      req_last_in_row <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      iv.sell_volume = sv;
      iv.sell_amount = sa;
      iv.buy_volume  = bv;
      iv.buy_amount  = ba;
      iv.last_in_row = last;
      bar_board.add_interval(iv);
   endtask

   task automatic send_row(input int len, input bit heavy);
      logic [VOL_W-1:0] sv, bv;
      for (int i = 0; i < len; i++) begin
         sv = rand_volume(heavy);
         bv = rand_volume(heavy);
         if ($urandom_range(0, 19) == 0) begin
            sv = '0;
            bv = '0;
         end
         send_request(sv, rand_amount(heavy), bv, rand_amount(heavy), i == len - 1);
      end
   endtask

   // let the block drain, then change the minimum interval count
   task automatic set_min_intervals(input logic [CFG_W-1:0] value);
      req_valid <= 1'b0;
      while (bar_board.pending_bars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      bar_board.min_intervals = value;
   endtask

   // result side: check each bar taken, stall at random or on a hold-off request
   initial begin
      bar_type got;
      int      hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            got.sell_volume_total = rsp_sell_volume_total;
            got.sell_amount_total = rsp_sell_amount_total;
            got.buy_volume_total  = rsp_buy_volume_total;
            got.buy_amount_total  = rsp_buy_amount_total;
            got.open_price        = rsp_open_price;
            got.close_price       = rsp_close_price;
            got.high_price        = rsp_high_price;
            got.low_price         = rsp_low_price;
            got.interval_count    = rsp_interval_count;
            got.kept              = rsp_kept;
            got.zero_volume_seen  = rsp_zero_volume_seen;
            bar_board.check_bar(got);
         end
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(0, 99) >= 14);
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // stimulus
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: all zero, all ones
      send_request('0, '0, '0, '0, 1'b1);
      send_request('1, '1, '1, '1, 1'b1);
      // saturated price, zero-volume interval mid-row, then a lower price
      send_request(VOL_W'(1), '1, '0, '1, 1'b0);
      send_request('0, '1, '0, '1, 1'b0);
      send_request(VOL_W'(7), AMT_W'(700), '0, '0, 1'b1);
      // rising, falling, truncating prices
      send_request(VOL_W'(10), AMT_W'(1000), '0, '0, 1'b0);
      send_request(VOL_W'(4), AMT_W'(800), VOL_W'(6), AMT_W'(1200), 1'b0);
      send_request('0, '0, VOL_W'(10), AMT_W'(500), 1'b0);
      send_request('0, '0, VOL_W'(3), AMT_W'(10), 1'b1);
      // open set only by the second interval
      send_request('0, AMT_W'(12345), '0, '0, 1'b0);
      send_request(VOL_W'(5), AMT_W'(55), VOL_W'(5), AMT_W'(45), 1'b1);
      // zero price from full buy volume and no amount
      send_request('0, '0, '1, '0, 1'b1);

      // rows either side of the reset minimum
      send_row(180, 1'b0);
      send_row(181, 1'b0);

      // minimum of zero, with the result side held off to back the block up
      set_min_intervals('0);
      hold_off_req = 1'b1;
      repeat (30) send_row(1, 1'b0);
      repeat (40) send_row($urandom_range(1, 6), 1'b0);

      // small minimum, no idling on either side
      set_min_intervals(CFG_W'(5));
      no_idle = 1'b1;
      send_row(5, 1'b0);
      send_row(6, 1'b0);
      repeat (25) send_row($urandom_range(1, 10), 1'b0);
      no_idle = 1'b0;

      // largest minimum: one long row saturating the totals and the count
      set_min_intervals('1);
      send_row(1030, 1'b1);
      repeat (10) send_row($urandom_range(1, 8), 1'b0);

      set_min_intervals(CFG_W'($urandom_range(1, 1022)));
      repeat (20) send_row($urandom_range(1, 8), 1'b0);

      // drain
      req_valid <= 1'b0;
      while (bar_board.pending_bars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bar_board.failures == 0 && bar_board.pending_bars.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
